/* hdl/learning_switch_with_tcp_flow_events_defines.svh */
// Assertion macros for the learning switch block.
// Included by the top level; needs nothing else.
`ifndef LEARNING_SWITCH_WITH_TCP_FLOW_EVENTS_DEFINES_SVH
`define LEARNING_SWITCH_WITH_TCP_FLOW_EVENTS_DEFINES_SVH

// Implication checked in the same cycle.
`define LSW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define LSW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/lsw_pkg.sv */
// Shared types and constants of the learning switch.
// No dependencies.
`default_nettype none
package lsw_pkg;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam int          FLAG_FIN       = 0;
    localparam int          FLAG_SYN       = 1;
    localparam int          FLAG_RST       = 2;
    localparam int          GROUP_BIT      = 40;

    typedef enum logic [1:0] {
        KIND_SYN = 2'd0,
        KIND_FIN = 2'd1,
        KIND_RST = 2'd2
    } t_kind;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_UPDATE = 5'b00100,
        S_READ   = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    // Classified request handed from the front to the back.
    typedef struct packed {
        logic [47:0] dmac;
        logic [47:0] smac;
        logic [7:0]  port;
        logic        dmac_group;
        logic        smac_group;
        logic        event_valid;
        logic [1:0]  event_kind;
        logic [31:0] low_address;
        logic [31:0] high_address;
        logic [31:0] event_seconds;
        logic [29:0] event_nanoseconds;
    } t_job;
endpackage
`default_nettype wire

/* hdl/lsw_front.sv */
// Front end: classifies each request and holds it in a two-entry queue.
// Depends on lsw_pkg.
`default_nettype none
module lsw_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_ready,
    input  wire  [261:0]    i_data,
    output logic            o_job_valid,
    output lsw_pkg::t_job   o_job,
    input  wire             i_job_pop
);
    lsw_pkg::t_job r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    lsw_pkg::t_job w_job;
    logic [31:0]   w_src, w_dst;
    logic [7:0]    w_flags;
    logic          w_push;

    assign w_src   = i_data[159:128];
    assign w_dst   = i_data[191:160];
    assign w_flags = i_data[199:192];

    always_comb begin
        w_job.dmac       = i_data[47:0];
        w_job.smac       = i_data[95:48];
        w_job.port       = i_data[103:96];
        w_job.dmac_group = i_data[lsw_pkg::GROUP_BIT];
        w_job.smac_group = i_data[48 + lsw_pkg::GROUP_BIT];
        w_job.event_valid = (i_data[119:104] == lsw_pkg::ETHERTYPE_IPV4)
            && (i_data[127:120] == lsw_pkg::PROTO_TCP)
            && (w_flags[lsw_pkg::FLAG_SYN] || w_flags[lsw_pkg::FLAG_FIN]
                || w_flags[lsw_pkg::FLAG_RST]);
        if (w_flags[lsw_pkg::FLAG_SYN]) begin
            w_job.event_kind = lsw_pkg::KIND_SYN;
        end else if (w_flags[lsw_pkg::FLAG_FIN]) begin
            w_job.event_kind = lsw_pkg::KIND_FIN;
        end else begin
            w_job.event_kind = lsw_pkg::KIND_RST;
        end
        w_job.low_address       = (w_src < w_dst) ? w_src : w_dst;
        w_job.high_address      = (w_src < w_dst) ? w_dst : w_src;
        w_job.event_seconds     = i_data[231:200];
        w_job.event_nanoseconds = i_data[261:232];
        // zero the event fields when no event is reported
        if (!w_job.event_valid) begin
            w_job.event_kind        = lsw_pkg::KIND_SYN;
            w_job.low_address       = 32'd0;
            w_job.high_address      = 32'd0;
            w_job.event_seconds     = 32'd0;
            w_job.event_nanoseconds = 30'd0;
        end
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_job_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_job_pop};
        end
    end
endmodule
`default_nettype wire

/* hdl/lsw_back.sv */
// Back end: scans the MAC table, learns the source and looks up the
// destination. Depends on lsw_pkg.
`default_nettype none
module lsw_back #(
    parameter int TABLE_ENTRIES = 256
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_job_valid,
    input  lsw_pkg::t_job   i_job,
    output logic            o_job_pop,
    output logic            o_valid,
    input  wire             i_ready,
    output logic [137:0]    o_data
);
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    logic [47:0] r_keys  [TABLE_ENTRIES];
    logic [7:0]  r_ports [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;

    lsw_pkg::t_state r_state;
    logic [CW-1:0] r_addr;
    logic [47:0]   r_rd_key;
    logic [IW-1:0] r_rd_idx;
    logic          r_rd_vld;
    logic          r_src_hit, r_free_hit, r_dst_hit;
    logic [IW-1:0] r_src_idx, r_free_idx, r_dst_idx;
    logic [7:0]    r_rd_port;
    logic          r_flood, r_use_mem;
    logic [7:0]    r_port;
    logic          w_learn, w_cmp_vld, w_out_free;
    logic [7:0]    w_port;

    assign w_learn    = !i_job.smac_group;
    assign w_cmp_vld  = r_rd_vld && r_valid[r_rd_idx];
    assign w_out_free = !o_valid || i_ready;
    assign o_job_pop  = (r_state == lsw_pkg::S_RESULT) && w_out_free;
    assign w_port     = r_flood ? 8'd0 : (r_use_mem ? r_rd_port : r_port);

    // key memory: read during the scan, written on learning a new source
    always_ff @(posedge i_clk) begin
        if (r_state == lsw_pkg::S_UPDATE && w_learn && !r_src_hit && r_free_hit) begin
            r_keys[r_free_idx] <= i_job.smac;
        end
        r_rd_key <= r_keys[r_addr[IW-1:0]];
    end

    // port memory: read for the destination, written when a source is learned or refreshed
    always_ff @(posedge i_clk) begin
        if (r_state == lsw_pkg::S_UPDATE && w_learn && (r_src_hit || r_free_hit)) begin
            r_ports[r_src_hit ? r_src_idx : r_free_idx] <= i_job.port;
        end
        r_rd_port <= r_ports[r_dst_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lsw_pkg::S_IDLE;
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            // drop the result once taken, unless a new one loads this cycle
            if (o_valid && i_ready && !o_job_pop) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                lsw_pkg::S_IDLE: begin
                    r_addr     <= '0;
                    r_rd_vld   <= 1'b0;
                    r_src_hit  <= 1'b0;
                    r_free_hit <= 1'b0;
                    r_dst_hit  <= 1'b0;
                    if (i_job_valid) begin
                        r_state <= lsw_pkg::S_SCAN;
                    end
                end
                lsw_pkg::S_SCAN: begin
                    // advance the read address; compare the entry read last cycle
                    if (r_addr < CW'(TABLE_ENTRIES)) begin
                        r_rd_idx <= r_addr[IW-1:0];
                        r_rd_vld <= 1'b1;
                        r_addr   <= r_addr + 1'b1;
                    end else begin
                        r_rd_vld <= 1'b0;
                        if (!r_rd_vld) begin
                            r_state <= lsw_pkg::S_UPDATE;
                        end
                    end
                    if (w_cmp_vld && r_rd_key == i_job.smac && !r_src_hit) begin
                        r_src_hit <= 1'b1;
                        r_src_idx <= r_rd_idx;
                    end
                    if (w_cmp_vld && r_rd_key == i_job.dmac && !r_dst_hit) begin
                        r_dst_hit <= 1'b1;
                        r_dst_idx <= r_rd_idx;
                    end
                    if (r_rd_vld && !r_valid[r_rd_idx] && !r_free_hit) begin
                        r_free_hit <= 1'b1;
                        r_free_idx <= r_rd_idx;
                    end
                end
                lsw_pkg::S_UPDATE: begin
                    if (w_learn && !r_src_hit && r_free_hit) begin
                        r_valid[r_free_idx] <= 1'b1;
                    end
                    r_port <= i_job.port;
                    if (i_job.dmac_group) begin
                        r_flood   <= 1'b1;
                        r_use_mem <= 1'b0;
                        r_state   <= lsw_pkg::S_RESULT;
                    end else if (i_job.dmac == i_job.smac && (r_src_hit || r_free_hit)) begin
                        r_flood   <= 1'b0;
                        r_use_mem <= 1'b0;
                        r_state   <= lsw_pkg::S_RESULT;
                    end else if (r_dst_hit) begin
                        r_flood   <= 1'b0;
                        r_use_mem <= 1'b1;
                        r_state   <= lsw_pkg::S_READ;
                    end else begin
                        r_flood   <= 1'b1;
                        r_use_mem <= 1'b0;
                        r_state   <= lsw_pkg::S_RESULT;
                    end
                end
                lsw_pkg::S_READ: begin
                    r_state <= lsw_pkg::S_RESULT;
                end
                lsw_pkg::S_RESULT: begin
                    if (w_out_free) begin
                        o_valid <= 1'b1;
                        o_data  <= {i_job.event_nanoseconds, i_job.event_seconds,
                                    i_job.high_address, i_job.low_address,
                                    i_job.event_kind, i_job.event_valid,
                                    w_port, r_flood};
                        r_state <= lsw_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= lsw_pkg::S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

/* hdl/learning_switch_with_tcp_flow_events.sv */
// Top level of the MAC learning switch with TCP flow event reporting.
// Depends on lsw_pkg, lsw_front, lsw_back and the defines header.
//
// Usage:
//   Slave channel (s_axis_*) takes one request per packet: parsed header
//   fields packed in s_axis_tdata. Master channel (m_axis_*) returns one
//   result per request, in order: forwarding decision plus an optional
//   SYN/FIN/RST event with the ordered IPv4 pair and the timestamp.
//   The front classifies the request (event kind, address order, group
//   bits) and parks it in a two-entry queue, so it keeps taking requests
//   while the back is busy.
//   The back walks the whole MAC table, one entry per cycle through the
//   key memory read port, then learns the source and fetches the port.
//   The back takes one request at a time and pops it only with its result;
//   the table scan sets the throughput.
//   Reset clears all table valid bits, the queue and the output register
//   at once; no clearing pass is needed.
//   When the receiver stalls, the result holds in the output register,
//   the back waits with the next result and the queue fills, after which
//   s_axis_tready drops.
`default_nettype none
`include "learning_switch_with_tcp_flow_events_defines.svh"
module learning_switch_with_tcp_flow_events #(
    parameter int TABLE_ENTRIES = 256
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            s_axis_tvalid,
    output logic           s_axis_tready,
    // dest_mac, source_mac, arrival_port, ether_type, ip_protocol,
    // ip_source, ip_dest, tcp_flags, stamp_seconds, stamp_nanoseconds, pad
    input  wire  [263:0]   s_axis_tdata,
    output logic           m_axis_tvalid,
    input  wire            m_axis_tready,
    // flood, egress_port, event_valid, event_kind, low_address,
    // high_address, event_seconds, event_nanoseconds, pad
    output logic [143:0]   m_axis_tdata
);
    logic          w_job_valid;
    logic          w_job_pop;
    lsw_pkg::t_job w_job;
    logic [137:0]  w_out;

    // front: classify and queue
    lsw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (s_axis_tdata[261:0]),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_pop   (w_job_pop)
    );

    // back: table scan, learn, lookup, output register
    lsw_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_pop   (w_job_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (w_out)
    );

    assign m_axis_tdata = {6'd0, w_out};

    `LSW_ASSERT_NOW(a_flood_port_zero, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[8:1] == 8'd0,
        "flood result carries a port")
    `LSW_ASSERT_NOW(a_no_event_zero, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tdata[9], m_axis_tdata[137:10] == 128'd0,
        "event fields set without an event")
    `LSW_ASSERT_NOW(a_pop_needs_job, i_clk, i_rst_n,
        w_job_pop, w_job_valid, "back popped an empty queue")
    `LSW_ASSERT_NEXT(a_pop_loads_out, i_clk, i_rst_n,
        w_job_pop, m_axis_tvalid, "popped request left no result")
endmodule
`default_nettype wire
